>>> rtl/core/rfvd_pkg.sv
// ---------------------------------------------------------------------------
// rfvd_pkg: shared types, constants and helpers
// Payload structs, register indexes and fixed-point helpers for the radial
// falloff vertex displacement unit.
// ---------------------------------------------------------------------------
package rfvd_pkg;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int RADIUS_W  = 31;
  localparam int DROP_W    = 16;
  localparam int PAINT_W   = 17;
  localparam int WEIGHT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Q16.16 / Q0.16 / Q8.8 constants
  localparam logic [PAINT_W-1:0]  ONE_Q16    = 17'd65536;
  localparam logic [RADIUS_W-1:0] RADIUS_MIN = 31'd66;        // 0.001
  localparam logic [16:0]         WEIGHT_CAP = 17'd60948;     // 0.93
  localparam logic [DROP_W-1:0]   DROP_RST   = 16'd256;       // 1.0

  // Sideband carried alongside the weight computation
  localparam int RFVD_TAG_W = 3 * COORD_W + PAINT_W + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_X = 3'd0,
    CFG_CENTRE_Y = 3'd1,
    CFG_CENTRE_Z = 3'd2,
    CFG_DISP_X   = 3'd3,
    CFG_DISP_Y   = 3'd4,
    CFG_DISP_Z   = 3'd5,
    CFG_RADIUS   = 3'd6,
    CFG_DROPOFF  = 3'd7
  } cfg_idx_e;

  // Input transaction
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [PAINT_W-1:0]        paint_weight;
  } rfvd_in_t;

  // Output transaction
  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] new_z;
    logic                      moved;
  } rfvd_out_t;

  // Digit-by-digit square root state
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] res;
  } sqrt_st_t;

  // One step of the binary square root, step n uses bit 62-2n
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int unsigned n);
    logic [63:0] b;
    logic [63:0] t;
    sqrt_st_t    o;
    b = 64'd1 << (62 - 2 * n);
    t = s.res + b;
    if (s.x >= t) begin
      o.x   = s.x - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.x   = s.x;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // Full 64-bit integer square root (elaboration-time use)
  function automatic logic [63:0] isqrt64(logic [63:0] x);
    sqrt_st_t s;
    s.x   = x;
    s.res = 64'd0;
    for (int n = 0; n < 32; n++) begin
      s = sqrt_step(s, n);
    end
    return s.res;
  endfunction

  // Q0.30 constant 2^-(2^-(k+1))
  function automatic logic [29:0] exp_c(int k);
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int i = 0; i < k; i++) begin
      c = isqrt64(c << 30);
    end
    return c[29:0];
  endfunction

endpackage

>>> rtl/core/rfvd_weight.sv
// ---------------------------------------------------------------------------
// rfvd_weight: falloff weight pipeline
// From the squared distance: root, normalized base u = (r-d)/r, log2,
// scale by dropoff, exp2, cap. Fixed 68-stage pipeline with a sideband tag.
// ---------------------------------------------------------------------------
module rfvd_weight #(
  parameter int TAG_W = rfvd_pkg::RFVD_TAG_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [63:0]                    sum_i,
  input  logic [TAG_W-1:0]               tag_i,
  input  logic [rfvd_pkg::RADIUS_W-1:0]  radius_i,
  input  logic [rfvd_pkg::DROP_W-1:0]    dropoff_i,
  output logic                           valid_o,
  output logic [rfvd_pkg::WEIGHT_W-1:0]  weight_o,
  output logic [TAG_W-1:0]               tag_o
);
  import rfvd_pkg::*;

  // Stage map
  localparam int SQ_ST = 16;            // square root, two digits per stage
  localparam int DV_ST = 17;            // quotient, one bit per stage
  localparam int LG_ST = 17;            // normalize + 16 squarings
  localparam int EX_ST = 16;            // one fraction bit per stage
  localparam int N_ST  = SQ_ST + DV_ST + LG_ST + 1 + EX_ST + 1;

  typedef struct packed {
    logic [30:0] m;
    logic [4:0]  p;
    logic [15:0] frac;
    logic        zero;
  } log_st_t;

  typedef struct packed {
    logic [30:0] acc;
    logic [15:0] f;
    logic [12:0] ip;
    logic        zero;
  } exp_st_t;

  // Valid and tag line
  logic             v_q [N_ST];
  logic [TAG_W-1:0] t_q [N_ST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < N_ST; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < N_ST; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= tag_i;
      for (int s = 1; s < N_ST; s++) t_q[s] <= t_q[s-1];
    end
  end

  // Square root
  sqrt_st_t sq_q [SQ_ST];

  for (genvar j = 0; j < SQ_ST; j++) begin : g_sqrt
    sqrt_st_t src, mid, nxt;
    if (j == 0) begin : g_first
      assign src = '{x: sum_i, res: 64'd0};
    end else begin : g_next
      assign src = sq_q[j-1];
    end
    always_comb begin
      mid = sqrt_step(src, 2 * j);
      nxt = sqrt_step(mid, 2 * j + 1);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) sq_q[j] <= nxt;
    end
  end

  // Quotient u = ((r - d) << 16) / r, restoring, MSB first
  logic [30:0] dv_rem_q [DV_ST];
  logic [16:0] dv_quo_q [DV_ST];

  for (genvar j = 0; j < DV_ST; j++) begin : g_div
    logic [30:0] rem_n;
    logic [16:0] quo_n;
    if (j == 0) begin : g_first
      logic [30:0] rem0;
      logic        ge;
      always_comb begin
        rem0  = radius_i - sq_q[SQ_ST-1].res[30:0];
        ge    = (rem0 == radius_i);
        rem_n = ge ? 31'd0 : rem0;
        quo_n = {16'd0, ge};
      end
    end else begin : g_next
      logic [31:0] cand;
      logic        ge;
      always_comb begin
        cand  = {dv_rem_q[j-1], 1'b0};
        ge    = (cand >= {1'b0, radius_i});
        rem_n = ge ? 31'(cand - {1'b0, radius_i}) : cand[30:0];
        quo_n = {dv_quo_q[j-1][15:0], ge};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[j] <= rem_n;
        dv_quo_q[j] <= quo_n;
      end
    end
  end

  // log2 by normalize and repeated squaring of a Q1.30 mantissa
  log_st_t lg_q [LG_ST];

  for (genvar j = 0; j < LG_ST; j++) begin : g_log
    log_st_t nxt;
    if (j == 0) begin : g_norm
      logic [16:0] u;
      always_comb begin
        u        = dv_quo_q[DV_ST-1];
        nxt.p    = 5'd0;
        for (int b = 0; b < 17; b++) begin
          if (u[b]) nxt.p = 5'(b);
        end
        nxt.m    = 31'(u) << (5'd30 - nxt.p);
        nxt.frac = 16'd0;
        nxt.zero = (u == 17'd0);
      end
    end else begin : g_sq
      logic [61:0] prod;
      logic [31:0] m2;
      always_comb begin
        prod     = 62'(lg_q[j-1].m) * 62'(lg_q[j-1].m);
        m2       = prod[61:30];
        nxt      = lg_q[j-1];
        nxt.m    = m2[31] ? m2[31:1] : m2[30:0];
        nxt.frac = {lg_q[j-1].frac[14:0], m2[31]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) lg_q[j] <= nxt;
    end
  end

  // Exponent e = -log2(u) * dropoff, Q.16
  logic [20:0] nl;
  logic [36:0] e_prod;
  logic [28:0] em_e_q;
  logic        em_zero_q;

  always_comb begin
    nl     = {5'd16 - lg_q[LG_ST-1].p, 16'd0} - {5'd0, lg_q[LG_ST-1].frac};
    e_prod = 37'(nl) * 37'(dropoff_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      em_e_q    <= e_prod[36:8];
      em_zero_q <= lg_q[LG_ST-1].zero;
    end
  end

  // exp2 of the negated fraction: one constant multiply per bit
  exp_st_t ex_q [EX_ST];

  for (genvar k = 0; k < EX_ST; k++) begin : g_exp
    localparam logic [29:0] CK = exp_c(k);
    exp_st_t     src, nxt;
    logic [60:0] prod;
    if (k == 0) begin : g_first
      assign src = '{acc: 31'h4000_0000, f: em_e_q[15:0], ip: em_e_q[28:16],
                     zero: em_zero_q};
    end else begin : g_next
      assign src = ex_q[k-1];
    end
    always_comb begin
      prod    = 61'(src.acc) * 61'(CK);
      nxt     = src;
      nxt.acc = src.f[EX_ST-1-k] ? prod[60:30] : src.acc;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) ex_q[k] <= nxt;
    end
  end

  // Final scaling, special cases and cap
  logic [30:0] shifted;
  logic [16:0] w_raw;
  logic [15:0] weight_q;

  always_comb begin
    shifted = ex_q[EX_ST-1].acc >> (5'd14 + 5'(ex_q[EX_ST-1].ip[3:0]));
    if (ex_q[EX_ST-1].zero) begin
      w_raw = (dropoff_i == '0) ? ONE_Q16 : 17'd0;
    end else if (ex_q[EX_ST-1].ip[12:4] != '0) begin
      w_raw = 17'd0;
    end else begin
      w_raw = shifted[16:0];
    end
    if (w_raw > WEIGHT_CAP) w_raw = WEIGHT_CAP;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) weight_q <= w_raw[15:0];
  end

  assign valid_o  = v_q[N_ST-1];
  assign tag_o    = t_q[N_ST-1];
  assign weight_o = weight_q;

endmodule

>>> rtl/core/radial_falloff_vertex_displace_unit.sv
// ---------------------------------------------------------------------------
// radial_falloff_vertex_displace_unit: radial falloff vertex displacement
// Moves a Q16.16 vertex inside a configured sphere by a displacement scaled
// by a (1 - d/r)^dropoff falloff and the painted weight, saturating.
// ---------------------------------------------------------------------------
// Throughput: one vertex per cycle; the whole pipeline stalls only while
// the output register holds a result that is not taken.
// Reset: pipeline empty; centre and displacement 0, radius 0 (block
// disabled), dropoff 1.0.
module radial_falloff_vertex_displace_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rfvd_pkg::rfvd_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rfvd_pkg::rfvd_out_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [rfvd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rfvd_pkg::CFG_DAT_W-1:0]   cfg_data_i
);
  import rfvd_pkg::*;

  localparam int W = COORD_W;

  // Configuration registers
  logic signed [W-1:0]  centre_q [3];
  logic signed [W-1:0]  disp_q   [3];
  logic [RADIUS_W-1:0]  radius_q;
  logic [DROP_W-1:0]    dropoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        centre_q[i] <= '0;
        disp_q[i]   <= '0;
      end
      radius_q  <= '0;
      dropoff_q <= DROP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTRE_X: centre_q[0] <= cfg_data_i[W-1:0];
        CFG_CENTRE_Y: centre_q[1] <= cfg_data_i[W-1:0];
        CFG_CENTRE_Z: centre_q[2] <= cfg_data_i[W-1:0];
        CFG_DISP_X:   disp_q[0]   <= cfg_data_i[W-1:0];
        CFG_DISP_Y:   disp_q[1]   <= cfg_data_i[W-1:0];
        CFG_DISP_Z:   disp_q[2]   <= cfg_data_i[W-1:0];
        CFG_RADIUS:   radius_q    <= cfg_data_i[RADIUS_W-1:0];
        CFG_DROPOFF:  dropoff_q   <= cfg_data_i[DROP_W-1:0];
      endcase
    end
  end

  // Global advance: move while the output register is free or drains
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage A: offsets from centre, per-axis reject
  logic signed [W-1:0]  pos_in [3];
  logic signed [W:0]    diff   [3];
  logic [W:0]           absd   [3];
  logic [2:0]           far;
  logic [PAINT_W-1:0]   pw_sat;

  always_comb begin
    pos_in[0] = in_data_i.pos_x;
    pos_in[1] = in_data_i.pos_y;
    pos_in[2] = in_data_i.pos_z;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {pos_in[i][W-1], pos_in[i]} - {centre_q[i][W-1], centre_q[i]};
      absd[i] = diff[i][W] ? (W+1)'(-diff[i]) : diff[i];
      far[i]  = absd[i] >= (W+1)'(radius_q);
    end
    pw_sat = (in_data_i.paint_weight > ONE_Q16) ? ONE_Q16 : in_data_i.paint_weight;
  end

  logic                va_q;
  logic signed [W-1:0] posa_q [3];
  logic [PAINT_W-1:0]  pwa_q;
  logic                ina_q;
  logic [RADIUS_W-1:0] aa_q   [3];

  // Stage B: squares
  logic                vb_q;
  logic signed [W-1:0] posb_q [3];
  logic [PAINT_W-1:0]  pwb_q;
  logic                inb_q;
  logic [61:0]         sqb_q  [3];
  logic [61:0]         rrb_q;

  // Stage C: distance sum and sphere test
  logic                vc_q;
  logic [63:0]         sumc_q;
  logic signed [W-1:0] posc_q [3];
  logic [PAINT_W-1:0]  pwc_q;
  logic                inc_q;
  logic [63:0]         sum_b;

  assign sum_b = 64'(sqb_q[0]) + 64'(sqb_q[1]) + 64'(sqb_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        posa_q[i] <= pos_in[i];
        aa_q[i]   <= absd[i][RADIUS_W-1:0];
        posb_q[i] <= posa_q[i];
        sqb_q[i]  <= 62'(aa_q[i]) * 62'(aa_q[i]);
        posc_q[i] <= posb_q[i];
      end
      pwa_q  <= pw_sat;
      ina_q  <= (radius_q >= RADIUS_MIN) && (far == 3'b000);
      pwb_q  <= pwa_q;
      inb_q  <= ina_q;
      rrb_q  <= 62'(radius_q) * 62'(radius_q);
      sumc_q <= sum_b;
      pwc_q  <= pwb_q;
      inc_q  <= inb_q && (sum_b < 64'(rrb_q));
    end
  end

  // Falloff weight pipeline
  logic [RFVD_TAG_W-1:0] tag_in, tag_out;
  logic                  vw;
  logic [WEIGHT_W-1:0]   weight;

  assign tag_in = {posc_q[0], posc_q[1], posc_q[2], pwc_q, inc_q};

  rfvd_weight #(
    .TAG_W (RFVD_TAG_W)
  ) u_weight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (vc_q),
    .sum_i     (sumc_q),
    .tag_i     (tag_in),
    .radius_i  (radius_q),
    .dropoff_i (dropoff_q),
    .valid_o   (vw),
    .weight_o  (weight),
    .tag_o     (tag_out)
  );

  logic signed [W-1:0] posw [3];
  logic [PAINT_W-1:0]  pww;
  logic                inw;

  assign posw[0] = tag_out[RFVD_TAG_W-1 -: W];
  assign posw[1] = tag_out[RFVD_TAG_W-1-W -: W];
  assign posw[2] = tag_out[RFVD_TAG_W-1-2*W -: W];
  assign pww     = tag_out[PAINT_W:1];
  assign inw     = tag_out[0];

  // Stage D: combined scale kq, stage E: displacement products
  logic [33:0]         kq_full;
  logic                vd_q, ve_q;
  logic [15:0]         kq_q;
  logic signed [W-1:0] posd_q [3];
  logic signed [W-1:0] pose_q [3];
  logic                ind_q, ine_q;
  logic signed [W+16:0] prod_q [3];

  assign kq_full = 34'(weight) * 34'(pww);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en) begin
      vd_q <= vw;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kq_q  <= kq_full[31:16];
      ind_q <= inw;
      ine_q <= ind_q;
      for (int i = 0; i < 3; i++) begin
        posd_q[i] <= posw[i];
        pose_q[i] <= posd_q[i];
        prod_q[i] <= disp_q[i] * $signed({1'b0, kq_q});
      end
    end
  end

  // Stage F: add offset (floor), saturate, output register
  logic signed [W+1:0] sum_f [3];
  logic signed [W-1:0] new_c [3];
  rfvd_out_t           out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_f[i] = {{2{pose_q[i][W-1]}}, pose_q[i]}
               + {prod_q[i][W+16], prod_q[i][W+16:16]};
      if (!ine_q) begin
        new_c[i] = pose_q[i];
      end else if (!sum_f[i][W+1] && (sum_f[i][W:W-1] != 2'b00)) begin
        new_c[i] = {1'b0, {(W-1){1'b1}}};
      end else if (sum_f[i][W+1] && (sum_f[i][W:W-1] != 2'b11)) begin
        new_c[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        new_c[i] = sum_f[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.new_x <= new_c[0];
      out_q.new_y <= new_c[1];
      out_q.new_z <= new_c[2];
      out_q.moved <= ine_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> bench/radial_falloff_vertex_displace_unit_test.sv
// ---------------------------------------------------------------------------
// radial_falloff_vertex_displace_unit_test: self-checking bench
// Streams vertices through the displacement unit under random idling and
// back-pressure, predicts each deformed vertex in fixed point and compares
// every result field by field, over several register settings.
// ---------------------------------------------------------------------------
module radial_falloff_vertex_displace_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rfvd_pkg::*;

  localparam int LATENCY   = 74;
  localparam int MAX_CYCLE = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  rfvd_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rfvd_out_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  radial_falloff_vertex_displace_unit DUT (.*);

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the registers
  logic signed [63:0] centre_q[3];
  logic signed [63:0] disp_q[3];
  logic [63:0]        radius_q;
  logic [63:0]        dropoff_q;

  rfvd_in_t  vertex_q[$];
  rfvd_out_t deformed_q[$];
  int        errors = 0;
  int        cycle = 0;
  int        hold_off = 0;
  bit        long_stall_req = 1'b0;

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // -log2(u / 65536) in Q.16
  function automatic logic [63:0] neg_log2(logic [63:0] u);
    int unsigned p;
    logic [63:0] m, frac;
    p = 0;
    frac = 0;
    while (p < 16 && (u >> (p + 1)) != 0) p++;
    m = u << (30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        frac |= 64'd1 << (15 - i);
        m >>= 1;
      end
    end
    return 64'(16 - p) * 64'd65536 - frac;
  endfunction

  // 2^-(e / 65536) in Q0.16
  function automatic logic [63:0] exp2_neg(logic [63:0] e);
    logic [63:0] acc, c;
    acc = 64'd1 << 30;
    c = root64(64'd1 << 59);
    if ((e >> 16) >= 16) return 0;
    for (int k = 0; k < 16; k++) begin
      if (e[15 - k]) acc = (acc * c) >> 30;
      c = root64(c << 30);
    end
    return acc >> (14 + (e >> 16));
  endfunction

  function automatic rfvd_out_t displace_vertex(rfvd_in_t v);
    logic signed [63:0] pos[3];
    logic signed [63:0] diff, off, hi, lo, dv;
    logic [63:0] a, sum, d, u, w, pw, kq, prod;
    bit          in_sphere;
    rfvd_out_t   o;
    pos[0] = 64'(v.pos_x);
    pos[1] = 64'(v.pos_y);
    pos[2] = 64'(v.pos_z);
    sum = 0;
    in_sphere = radius_q >= 64'(RADIUS_MIN);
    for (int i = 0; i < 3; i++) begin
      diff = pos[i] - centre_q[i];
      a = diff < 0 ? 64'(-diff) : 64'(diff);
      if (a >= radius_q) in_sphere = 1'b0;
      else sum += a * a;
    end
    if (in_sphere && sum >= radius_q * radius_q) in_sphere = 1'b0;
    if (in_sphere) begin
      d = root64(sum);
      u = ((radius_q - d) << 16) / radius_q;
      if (u == 0) w = (dropoff_q == 0) ? 64'd65536 : 64'd0;
      else w = exp2_neg((neg_log2(u) * dropoff_q) >> 8);
      if (w > 64'(WEIGHT_CAP)) w = 64'(WEIGHT_CAP);
      pw = 64'(v.paint_weight);
      if (pw > 64'd65536) pw = 64'd65536;
      kq = (w * pw) >> 16;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      for (int i = 0; i < 3; i++) begin
        dv = disp_q[i];
        if (dv >= 0) begin
          off = 64'((64'(dv) * kq) >> 16);
        end else begin
          prod = 64'(-dv) * kq;
          off = -64'((prod + 64'd65535) >> 16);
        end
        pos[i] = pos[i] + off;
        if (pos[i] > hi) pos[i] = hi;
        if (pos[i] < lo) pos[i] = lo;
      end
    end
    o.new_x = pos[0][31:0];
    o.new_y = pos[1][31:0];
    o.new_z = pos[2][31:0];
    o.moved = in_sphere;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle);
    errors++;
  endtask

  // Register write, mirrored into the predictor
  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx) inside
      CFG_CENTRE_X, CFG_CENTRE_Y, CFG_CENTRE_Z: begin
        centre_q[int'(idx)] = 64'(signed'(value));
      end
      CFG_DISP_X, CFG_DISP_Y, CFG_DISP_Z: begin
        disp_q[int'(idx) - 3] = 64'(signed'(value));
      end
      CFG_RADIUS: radius_q = 64'(value[30:0]);
      CFG_DROPOFF: dropoff_q = 64'(value[15:0]);
      default: ;
    endcase
  endtask

  // Sender pause until every expected result has come back
  task automatic wait_drained();
    while (vertex_q.size() != 0 || deformed_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_coord(int scale);
    logic [31:0] r;
    r = $urandom();
    case (scale)
      0: return 32'(signed'(r[19:0]));           // near origin
      1: return 32'(signed'(r[23:0]));
      default: return r;
    endcase
  endfunction

  // Vertex near the centre so that most land inside the sphere
  function automatic rfvd_in_t rand_vertex();
    rfvd_in_t v;
    int mode;
    mode = $urandom_range(0, 9);
    v.pos_x = (mode < 7) ? 32'(centre_q[0]) + rand_coord(0) : rand_coord(2);
    v.pos_y = (mode < 7) ? 32'(centre_q[1]) + rand_coord(0) : rand_coord(2);
    v.pos_z = (mode < 7) ? 32'(centre_q[2]) + rand_coord(0) : rand_coord(2);
    case ($urandom_range(0, 5))
      0: v.paint_weight = ONE_Q16;
      1: v.paint_weight = 17'h1FFFF - 17'($urandom_range(0, 3));
      default: v.paint_weight = 17'($urandom_range(0, 131071));
    endcase
    return v;
  endfunction

  // Input transaction seen at the rising edge
  bit accepted_in = 1'b0;

  // Driver
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || accepted_in) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (vertex_q.size() != 0) begin
          in_data_i <= vertex_q.pop_front();
          in_valid_i <= 1'b1;
          send_gap <= gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Predict on acceptance
  always @(posedge clk_i) begin
    accepted_in <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) deformed_q.push_back(displace_vertex(in_data_i));
  end

  // Receiver readiness, with an occasional long hold-off
  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (long_stall_req) begin
      out_ready_i <= 1'b0;
      if (hold_off >= 300) begin
        long_stall_req <= 1'b0;
        hold_off <= 0;
      end else begin
        hold_off <= hold_off + 1;
      end
    end else if (recv_gap > 0) begin
      out_ready_i <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      recv_gap <= gap_len();
    end
  end

  // Monitor
  rfvd_out_t want;
  always @(posedge clk_i) begin
    if (rst_ni) cycle <= cycle + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (deformed_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data_o), 0);
      end else begin
        want = deformed_q.pop_front();
        if (out_data_o.new_x !== want.new_x) report_mismatch("new_x", out_data_o.new_x, want.new_x);
        if (out_data_o.new_y !== want.new_y) report_mismatch("new_y", out_data_o.new_y, want.new_y);
        if (out_data_o.new_z !== want.new_z) report_mismatch("new_z", out_data_o.new_z, want.new_z);
        if (out_data_o.moved !== want.moved) report_mismatch("moved", out_data_o.moved, want.moved);
      end
    end
    if (cycle > MAX_CYCLE) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Register setting for one phase
  task automatic setup_phase(int ph);
    logic [31:0] r;
    write_reg(CFG_CENTRE_X, ph == 1 ? 32'h7FFF0000 : (ph == 2 ? 32'h80000000 : $urandom()));
    write_reg(CFG_CENTRE_Y, ph == 1 ? 32'h7FFFFFFF : (ph == 2 ? 32'h80000001 : $urandom()));
    write_reg(CFG_CENTRE_Z, ph == 1 ? 32'h0 : $urandom());
    write_reg(CFG_DISP_X, ph == 1 ? 32'h7FFFFFFF : (ph == 2 ? 32'h80000000 : $urandom()));
    write_reg(CFG_DISP_Y, ph == 1 ? 32'h80000000 : $urandom());
    write_reg(CFG_DISP_Z, $urandom());
    case (ph)
      0: r = 32'd65;
      1: r = 32'h7FFFFFFF;
      2: r = 32'd66;
      default: r = 32'($urandom_range(1 << 16, 1 << 22));
    endcase
    write_reg(CFG_RADIUS, r);
    case (ph)
      1: write_reg(CFG_DROPOFF, 32'hFFFF);
      2: write_reg(CFG_DROPOFF, 32'h0);
      default: write_reg(CFG_DROPOFF, 32'($urandom_range(0, 2048)));
    endcase
  endtask

  // Stimulus
  rfvd_in_t v;
  initial begin
    centre_q = '{0, 0, 0};
    disp_q = '{0, 0, 0};
    radius_q = 0;
    dropoff_q = 256;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset state (disabled), extremes, on-sphere and centre hits
    v = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 17'h1FFFF};
    vertex_q.push_back(v);
    wait_drained();
    write_reg(CFG_DISP_X, 32'h00010000);
    write_reg(CFG_DISP_Y, 32'hFFFF0000);
    write_reg(CFG_DISP_Z, 32'h7FFFFFFF);
    write_reg(CFG_RADIUS, 32'h00020000);
    wait_drained();
    vertex_q.push_back(rfvd_in_t'{32'h0, 32'h0, 32'h0, ONE_Q16});        // capped weight
    vertex_q.push_back(rfvd_in_t'{32'h00020000, 32'h0, 32'h0, ONE_Q16}); // on the sphere
    vertex_q.push_back(rfvd_in_t'{32'h0001FFFF, 32'h0, 32'h0, ONE_Q16}); // zero base
    vertex_q.push_back(rfvd_in_t'{32'h00010000, 32'h00001000, 32'h0, 17'd0});
    vertex_q.push_back(rfvd_in_t'{32'h00008000, 32'h0, 32'h0, 17'h1FFFF}); // paint above 1.0
    vertex_q.push_back(rfvd_in_t'{32'h7FFFFFF0, 32'h0, 32'h0, ONE_Q16});
    vertex_q.push_back(rfvd_in_t'{32'h0, 32'h0, 32'h7FFFF000, ONE_Q16});
    wait_drained();
    write_reg(CFG_CENTRE_Z, 32'h7FFFFFF0);
    write_reg(CFG_DROPOFF, 32'h0);
    vertex_q.push_back(rfvd_in_t'{32'h0, 32'h0, 32'h7FFFFFFF, ONE_Q16}); // saturates high
    vertex_q.push_back(rfvd_in_t'{32'h0001FFFF, 32'h0, 32'h7FFFFFF0, ONE_Q16});
    wait_drained();
    write_reg(CFG_DISP_Z, 32'h80000000);
    wait_drained();
    write_reg(CFG_CENTRE_Z, 32'h80000010);
    vertex_q.push_back(rfvd_in_t'{32'h0, 32'h0, 32'h80000000, ONE_Q16}); // saturates low
    wait_drained();

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      setup_phase(ph);
      if (ph == 3) long_stall_req = 1'b1;
      for (int n = 0; n < 150; n++) vertex_q.push_back(rand_vertex());
      wait_drained();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
